[hw/rtl/csm2d_pkg.sv]
// ============================================================================
// csm2d_pkg
// Shared types and constants of the 2D cubic spline momentum map.
// ============================================================================
package csm2d_pkg;

   localparam int CELL_W = 6;
   localparam int FRAC_W = 16;
   localparam int MOM_W  = 32;
   localparam int SUM_W  = 64;
   localparam int WSUM_W = 48;
   localparam int REG_W  = 6;
   localparam int W16_W  = 17;

   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_DEPOSIT = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;

   localparam logic [1:0] REG_X_LOW  = 2'd0;
   localparam logic [1:0] REG_X_HIGH = 2'd1;
   localparam logic [1:0] REG_Y_LOW  = 2'd2;
   localparam logic [1:0] REG_Y_HIGH = 2'd3;

   typedef struct packed {
      logic [SUM_W-1:0]  mx;
      logic [SUM_W-1:0]  my;
      logic [SUM_W-1:0]  mz;
      logic [WSUM_W-1:0] w;
   } sum_entry_type;

   typedef struct packed {
      logic       load;
      logic       clr_step;
      logic       spl_sq;
      logic       spl_cu;
      logic       spl_num;
      logic       spl_mul;
      logic       spl_cor;
      logic       stn_issue;
      logic [1:0] stn_a;
      logic [1:0] stn_b;
      logic       rd_issue;
      logic       rd_capture;
      logic       div_start;
      logic [1:0] div_sel;
      logic       set_drop;
      logic       rsp_load;
   } csm2d_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic in_region;
      logic rd_in_grid;
      logic div_done;
   } csm2d_status_type;

endpackage

[hw/rtl/csm2d_div.sv]
// ============================================================================
// csm2d_div
// Radix-2 restoring divider for the weighted mean: sum / weight in Q15.16,
// truncated toward zero and saturated to 32 signed bits. One bit per cycle.
// ============================================================================
module csm2d_div
   import csm2d_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [SUM_W-1:0]         num,
   input  logic [WSUM_W-1:0]        den,
   output logic                     done,
   output logic [MOM_W-1:0]         quot
);

   logic                neg_ff, zero_ff, sat_ff, busy_ff, fin_ff, done_ff;
   logic [4:0]          cnt_ff;
   logic [WSUM_W-1:0]   rem_ff, den_ff;
   logic [31:0]         shr_ff, q_ff;
   logic [MOM_W-1:0]    quot_ff;
   logic [SUM_W-1:0]    mag;
   logic [WSUM_W:0]     trial, diff;
   logic [MOM_W-1:0]    res_in;

   assign mag   = num[SUM_W-1] ? SUM_W'(-num) : num;
   assign trial = {rem_ff, shr_ff[31]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      if (zero_ff) begin
         res_in = '0;
      end else if (neg_ff) begin
         if (sat_ff || q_ff > 32'h8000_0000) begin
            res_in = 32'h8000_0000;
         end else begin
            res_in = 32'(-q_ff);
         end
      end else begin
         if (sat_ff || q_ff[31]) begin
            res_in = 32'h7FFF_FFFF;
         end else begin
            res_in = q_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            neg_ff  <= num[SUM_W-1];
            zero_ff <= (den == '0);
            sat_ff  <= (mag >= {den, 16'b0});
            rem_ff  <= mag[SUM_W-1:16];
            shr_ff  <= {mag[15:0], 16'b0};
            den_ff  <= den;
            q_ff    <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (trial >= {1'b0, den_ff}) begin
               rem_ff <= diff[WSUM_W-1:0];
               q_ff   <= {q_ff[30:0], 1'b1};
            end else begin
               rem_ff <= trial[WSUM_W-1:0];
               q_ff   <= {q_ff[30:0], 1'b0};
            end
            shr_ff <= {shr_ff[30:0], 1'b0};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            quot_ff <= res_in;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[hw/rtl/csm2d_dp.sv]
// ============================================================================
// csm2d_dp
// Datapath: region registers, spline weight unit, the cell store with its
// read-modify-write stencil pipeline, the mean divider and the result register.
// ============================================================================
module csm2d_dp
   import csm2d_pkg::*;
#(
   parameter int GRID_X    = 64,
   parameter int GRID_Y    = 64,
   parameter int FRAC_BITS = 16
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  csm2d_cmd_type           cmd,
   output csm2d_status_type        status,
   input  logic [CELL_W-1:0]       in_cell_x,
   input  logic [CELL_W-1:0]       in_cell_y,
   input  logic [FRAC_W-1:0]       in_frac_x,
   input  logic [FRAC_W-1:0]       in_frac_y,
   input  logic [MOM_W-1:0]        in_mom_x,
   input  logic [MOM_W-1:0]        in_mom_y,
   input  logic [MOM_W-1:0]        in_mom_z,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [REG_W-1:0]        csr_wdata,
   output logic                    out_status,
   output logic [MOM_W-1:0]        out_mean_x,
   output logic [MOM_W-1:0]        out_mean_y,
   output logic [MOM_W-1:0]        out_mean_z,
   output logic [WSUM_W-1:0]       out_weight_total
);

   localparam int CELLS = GRID_X * GRID_Y;
   localparam int AW    = $clog2(CELLS);
   localparam int FB    = FRAC_BITS;
   localparam int TW    = FB + 1;
   localparam int YW    = FB + 2;
   localparam int NW    = FB + 4;
   localparam int RSH   = (FB > 16) ? FB - 16 : 0;
   localparam int LSH   = (FB < 16) ? 16 - FB : 0;
   localparam logic [TW-1:0]   ONE     = {1'b1, {FB{1'b0}}};
   localparam logic [2*TW-1:0] HALF_SQ = {{(TW+1){1'b0}}, 1'b1, {(FB-1){1'b0}}};
   localparam logic [YW-1:0]   MRECIP  = YW'((64'd1 << YW) / 3);
   localparam logic [FB+16:0]  HALF_W  = (FB+17)'((1 << RSH) >> 1);

   // Configuration registers.
   logic [REG_W-1:0] xl_ff, xh_ff, yl_ff, yh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xl_ff <= REG_W'(2);
         xh_ff <= REG_W'(60);
         yl_ff <= REG_W'(2);
         yh_ff <= REG_W'(60);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_X_LOW:  xl_ff <= csr_wdata;
            REG_X_HIGH: xh_ff <= csr_wdata;
            REG_Y_LOW:  yl_ff <= csr_wdata;
            REG_Y_HIGH: yh_ff <= csr_wdata;
            default:    xl_ff <= xl_ff;
         endcase
      end
   end

   // Item latch.
   logic [CELL_W-1:0] cx_ff, cy_ff;
   logic              mneg_ff [3];
   logic [MOM_W-1:0]  mmag_ff [3];
   logic [MOM_W-1:0]  mom_in  [3];
   logic [FRAC_W-1:0] frac_in [2];
   logic [TW-1:0]     t_ff [2], u_ff [2], t2_ff [2], u2_ff [2], t3_ff [2], u3_ff [2];
   logic [YW-1:0]     y_ff  [2][4];
   logic [2*YW-1:0]   pr_ff [2][4];
   logic [FB-1:0]     wt_ff [2][4];

   assign mom_in[0]  = in_mom_x;
   assign mom_in[1]  = in_mom_y;
   assign mom_in[2]  = in_mom_z;
   assign frac_in[0] = in_frac_x;
   assign frac_in[1] = in_frac_y;

   function automatic logic [TW-1:0] rnd_fb(input logic [2*TW-1:0] p);
      logic [2*TW-1:0] s;
      s = (p + HALF_SQ) >> FB;
      return s[TW-1:0];
   endfunction

   function automatic logic [YW-1:0] half_num(input logic [TW-1:0] sq,
                                              input logic [TW-1:0] cu,
                                              input logic          mid);
      logic [NW-1:0] pos, sub, n;
      pos = (NW'(ONE) << 2) + NW'(cu) * NW'(3);
      sub = NW'(sq) * NW'(6);
      if (!mid) begin
         n = NW'(cu) + NW'(3);
      end else if (pos < sub) begin
         n = NW'(3);
      end else begin
         n = pos - sub + NW'(3);
      end
      return YW'(n >> 1);
   endfunction

   function automatic logic [FB-1:0] div3_fix(input logic [YW-1:0]   y,
                                              input logic [2*YW-1:0] pr);
      logic [YW+1:0] q0, r;
      q0 = (YW+2)'(pr >> YW);
      r  = (YW+2)'(y) - (q0 + (q0 << 1));
      if (r >= (YW+2)'(3)) begin
         q0 = q0 + (YW+2)'(1);
      end
      return q0[FB-1:0];
   endfunction

   always_ff @(posedge clock) begin
      logic [FB+15:0] tw;
      if (cmd.load) begin
         cx_ff <= in_cell_x;
         cy_ff <= in_cell_y;
         for (int i = 0; i < 3; i++) begin
            mneg_ff[i] <= mom_in[i][MOM_W-1];
            mmag_ff[i] <= mom_in[i][MOM_W-1] ? MOM_W'(-mom_in[i]) : mom_in[i];
         end
         for (int k = 0; k < 2; k++) begin
            tw = {frac_in[k], {FB{1'b0}}};
            t_ff[k] <= TW'(tw[FB+15:16]);
            u_ff[k] <= ONE - TW'(tw[FB+15:16]);
         end
      end
      for (int k = 0; k < 2; k++) begin
         if (cmd.spl_sq) begin
            t2_ff[k] <= rnd_fb((2*TW)'(t_ff[k]) * (2*TW)'(t_ff[k]));
            u2_ff[k] <= rnd_fb((2*TW)'(u_ff[k]) * (2*TW)'(u_ff[k]));
         end
         if (cmd.spl_cu) begin
            t3_ff[k] <= rnd_fb((2*TW)'(t2_ff[k]) * (2*TW)'(t_ff[k]));
            u3_ff[k] <= rnd_fb((2*TW)'(u2_ff[k]) * (2*TW)'(u_ff[k]));
         end
         if (cmd.spl_num) begin
            y_ff[k][0] <= half_num(u2_ff[k], u3_ff[k], 1'b0);
            y_ff[k][1] <= half_num(t2_ff[k], t3_ff[k], 1'b1);
            y_ff[k][2] <= half_num(u2_ff[k], u3_ff[k], 1'b1);
            y_ff[k][3] <= half_num(t2_ff[k], t3_ff[k], 1'b0);
         end
         for (int j = 0; j < 4; j++) begin
            if (cmd.spl_mul) begin
               pr_ff[k][j] <= (2*YW)'(y_ff[k][j]) * (2*YW)'(MRECIP);
            end
            if (cmd.spl_cor) begin
               wt_ff[k][j] <= div3_fix(y_ff[k][j], pr_ff[k][j]);
            end
         end
      end
   end

   assign status.in_region = (cx_ff >= xl_ff) && (cx_ff <= xh_ff) &&
                             (cy_ff >= yl_ff) && (cy_ff <= yh_ff);
   assign status.rd_in_grid = (32'(cx_ff) < GRID_X) && (32'(cy_ff) < GRID_Y);

   // Cell store.
   sum_entry_type  mem [CELLS];
   sum_entry_type  rd_q_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   sum_entry_type  mem_wdata;

   // Clearing sweep counter.
   logic [AW-1:0] clr_cnt_ff;
   assign status.clr_last = (clr_cnt_ff == AW'(CELLS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= status.clr_last ? '0 : clr_cnt_ff + AW'(1);
      end
   end

   // Stencil stage 0: cell address and weight product.
   logic [7:0]      gx, gy;
   logic            s0_v;
   logic [AW-1:0]   s0_addr, rd_addr;
   logic            s1_v_ff, s2_v_ff;
   logic [AW-1:0]   s1_addr_ff, s2_addr_ff;
   logic [2*FB-1:0] s1_p_ff;
   logic [48:0]     s2_p_ff [3];
   logic [W16_W-1:0] s2_w16_ff;
   sum_entry_type   s2_old_ff;

   assign gx      = 8'(cx_ff) + 8'(cmd.stn_a);
   assign gy      = 8'(cy_ff) + 8'(cmd.stn_b);
   assign s0_v    = cmd.stn_issue && (gx != 8'd0) && (gy != 8'd0) &&
                    (32'(gx) <= GRID_X) && (32'(gy) <= GRID_Y);
   assign s0_addr = AW'(32'(gx - 8'd1) * GRID_Y + 32'(gy - 8'd1));
   assign rd_addr = AW'(32'(cx_ff) * GRID_Y + 32'(cy_ff));
   assign mem_raddr = cmd.rd_issue ? rd_addr : s0_addr;

   // Stage 1: weight rounded to Q0.16 and the three momentum products.
   logic [2*FB:0]   w_full;
   logic [FB+16:0]  w_ext;
   logic [W16_W-1:0] w16;

   always_comb begin
      w_full = ((2*FB+1)'(s1_p_ff) + ((2*FB+1)'(1) << (FB - 1))) >> FB;
      w_ext  = (FB+17)'(w_full);
      if (FB >= 16) begin
         w16 = W16_W'((w_ext + HALF_W) >> RSH);
      end else begin
         w16 = W16_W'(w_ext << LSH);
      end
   end

   // Stage 2: signed shares added into the old sums.
   logic [SUM_W-1:0] share [3];
   logic [33:0]      shr_mag [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shr_mag[i] = 34'((s2_p_ff[i] + 49'h8000) >> 16);
         share[i]   = mneg_ff[i] ? SUM_W'(-{30'b0, shr_mag[i]}) : {30'b0, shr_mag[i]};
      end
      mem_we    = cmd.clr_step || s2_v_ff;
      mem_waddr = cmd.clr_step ? clr_cnt_ff : s2_addr_ff;
      if (cmd.clr_step) begin
         mem_wdata = '0;
      end else begin
         mem_wdata.mx = s2_old_ff.mx + share[0];
         mem_wdata.my = s2_old_ff.my + share[1];
         mem_wdata.mz = s2_old_ff.mz + share[2];
         mem_wdata.w  = s2_old_ff.w + WSUM_W'(s2_w16_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s0_v;
         s2_v_ff <= s1_v_ff;
      end
      s1_addr_ff <= s0_addr;
      s1_p_ff    <= (2*FB)'(wt_ff[0][cmd.stn_a]) * (2*FB)'(wt_ff[1][cmd.stn_b]);
      s2_addr_ff <= s1_addr_ff;
      s2_old_ff  <= rd_q_ff;
      s2_w16_ff  <= w16;
      for (int i = 0; i < 3; i++) begin
         s2_p_ff[i] <= 49'(mmag_ff[i]) * 49'(w16);
      end
   end

   // Mean division and result registers.
   sum_entry_type    op_ff;
   logic [SUM_W-1:0] div_num;
   logic [MOM_W-1:0] div_quot;
   logic             div_done;
   logic             res_status_ff, out_status_ff;
   logic [MOM_W-1:0] res_mean_ff [3];
   logic [MOM_W-1:0] out_mean_ff [3];
   logic [WSUM_W-1:0] res_wt_ff, out_wt_ff;

   always_comb begin
      case (cmd.div_sel)
         2'd0:    div_num = op_ff.mx;
         2'd1:    div_num = op_ff.my;
         default: div_num = op_ff.mz;
      endcase
   end

   csm2d_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (op_ff.w),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign status.div_done = div_done;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_status_ff <= 1'b0;
         res_wt_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            res_mean_ff[i] <= '0;
         end
      end else begin
         if (cmd.set_drop) begin
            res_status_ff <= 1'b1;
         end
         if (cmd.rd_capture) begin
            res_wt_ff <= rd_q_ff.w;
         end
         if (div_done) begin
            res_mean_ff[cmd.div_sel] <= div_quot;
         end
      end
      if (cmd.rd_capture) begin
         op_ff <= rd_q_ff;
      end
      if (cmd.rsp_load) begin
         out_status_ff <= res_status_ff;
         out_wt_ff     <= res_wt_ff;
         for (int i = 0; i < 3; i++) begin
            out_mean_ff[i] <= res_mean_ff[i];
         end
      end
   end

   assign out_status       = out_status_ff;
   assign out_mean_x       = out_mean_ff[0];
   assign out_mean_y       = out_mean_ff[1];
   assign out_mean_z       = out_mean_ff[2];
   assign out_weight_total = out_wt_ff;

endmodule

[hw/rtl/csm2d_ctrl.sv]
// ============================================================================
// csm2d_ctrl
// Controller: sequences clear sweeps, spline steps, the 4x4 stencil, the
// mean divisions and the response handshake.
// ============================================================================
module csm2d_ctrl
   import csm2d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output csm2d_cmd_type     cmd,
   input  csm2d_status_type  status
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_SQ, ST_CU, ST_NUM, ST_MUL, ST_COR,
      ST_STN, ST_DRAIN, ST_RDCHK, ST_RD1, ST_DIVGO, ST_DIVWAIT, ST_DONE
   } state_type;

   state_type  state_ff;
   logic       clr_rsp_ff, rsp_valid_ff, drain_ff;
   logic [3:0] k_ff;
   logic [1:0] sel_ff;
   logic       accept, out_free;

   assign accept   = (state_ff == ST_IDLE) && req_tvalid;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd            = '0;
      cmd.load       = accept;
      cmd.clr_step   = (state_ff == ST_CLEAR);
      cmd.spl_sq     = (state_ff == ST_SQ);
      cmd.spl_cu     = (state_ff == ST_CU);
      cmd.spl_num    = (state_ff == ST_NUM);
      cmd.spl_mul    = (state_ff == ST_MUL);
      cmd.spl_cor    = (state_ff == ST_COR);
      cmd.stn_issue  = (state_ff == ST_STN);
      cmd.stn_a      = k_ff[3:2];
      cmd.stn_b      = k_ff[1:0];
      cmd.rd_issue   = (state_ff == ST_RDCHK) && status.rd_in_grid;
      cmd.rd_capture = (state_ff == ST_RD1);
      cmd.div_start  = (state_ff == ST_DIVGO);
      cmd.div_sel    = sel_ff;
      cmd.set_drop   = (state_ff == ST_CHECK) && !status.in_region;
      cmd.rsp_load   = (state_ff == ST_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         drain_ff     <= 1'b0;
         k_ff         <= '0;
         sel_ff       <= '0;
      end else begin
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clr_last) begin
                  state_ff <= clr_rsp_ff ? ST_DONE : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  case (req_tuser)
                     CMD_CLEAR: begin
                        clr_rsp_ff <= 1'b1;
                        state_ff   <= ST_CLEAR;
                     end
                     CMD_DEPOSIT: state_ff <= ST_CHECK;
                     CMD_READ:    state_ff <= ST_RDCHK;
                     default:     state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_CHECK: state_ff <= status.in_region ? ST_SQ : ST_DONE;
            ST_SQ:    state_ff <= ST_CU;
            ST_CU:    state_ff <= ST_NUM;
            ST_NUM:   state_ff <= ST_MUL;
            ST_MUL:   state_ff <= ST_COR;
            ST_COR: begin
               k_ff     <= '0;
               state_ff <= ST_STN;
            end
            ST_STN: begin
               k_ff <= k_ff + 4'd1;
               if (k_ff == 4'd15) begin
                  drain_ff <= 1'b0;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // The drain lets the last stencil write reach the store.
               drain_ff <= 1'b1;
               if (drain_ff) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_RDCHK: state_ff <= status.rd_in_grid ? ST_RD1 : ST_DONE;
            ST_RD1: begin
               sel_ff   <= '0;
               state_ff <= ST_DIVGO;
            end
            ST_DIVGO: state_ff <= ST_DIVWAIT;
            ST_DIVWAIT: begin
               if (status.div_done) begin
                  if (sel_ff == 2'd2) begin
                     state_ff <= ST_DONE;
                  end else begin
                     sel_ff   <= sel_ff + 2'd1;
                     state_ff <= ST_DIVGO;
                  end
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  clr_rsp_ff <= 1'b0;
                  state_ff   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

[hw/rtl/cubic_spline_momentum_map_2d_unit.sv]
// ============================================================================
// cubic_spline_momentum_map_2d_unit
// Top level of the 2D cubic B-spline momentum deposition grid.
// ============================================================================
// Every request transaction gives exactly one response transaction. After
// reset, and after each clear command, the cell store is swept one cell per
// cycle over all GRID_X*GRID_Y cells (4096 by default), during which no
// request is taken. A deposit passes through the accepting cycle, the region
// check and the spline weight steps, one read-modify-write per stencil cell,
// the pipeline drain and the hand-over of the result. A read runs the shared
// one-bit-per-cycle divider once for each of the three momentum components,
// one after the other. Dropped deposits and reads outside the grid answer
// straight after their check, unused commands straight after acceptance. A
// new request is taken while the previous response still waits on rsp_tready.
module cubic_spline_momentum_map_2d_unit
   import csm2d_pkg::*;
#(
   parameter int GRID_X    = 64,
   parameter int GRID_Y    = 64,
   parameter int FRAC_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cell_x, cell_y, frac_x, frac_y, mom_x, mom_y, mom_z, zero pad
   input  logic [143:0]          req_tdata,
   // cmd
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // mean_x, mean_y, mean_z, weight_total
   output logic [143:0]          rsp_tdata,
   // status
   output logic [0:0]            rsp_tuser,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [REG_W-1:0]      csr_wdata
);

   csm2d_cmd_type    cmd;
   csm2d_status_type status;
   logic [MOM_W-1:0] mean_x, mean_y, mean_z;
   logic [WSUM_W-1:0] weight_total;
   logic             rsp_status;

   csm2d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   csm2d_dp #(
      .GRID_X    (GRID_X),
      .GRID_Y    (GRID_Y),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_cell_x        (req_tdata[5:0]),
      .in_cell_y        (req_tdata[11:6]),
      .in_frac_x        (req_tdata[27:12]),
      .in_frac_y        (req_tdata[43:28]),
      .in_mom_x         (req_tdata[75:44]),
      .in_mom_y         (req_tdata[107:76]),
      .in_mom_z         (req_tdata[139:108]),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .out_status       (rsp_status),
      .out_mean_x       (mean_x),
      .out_mean_y       (mean_y),
      .out_mean_z       (mean_z),
      .out_weight_total (weight_total)
   );

   assign rsp_tdata = {weight_total, mean_z, mean_y, mean_x};
   assign rsp_tuser = rsp_status;

endmodule

[hw/rtl/csm2d_checker.sv]
// ============================================================================
// csm2d_checker
// Port-level checks of the momentum map unit, bound to its top level.
// ============================================================================
module csm2d_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [143:0]  rsp_tdata,
   input logic [0:0]    rsp_tuser
);

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // A dropped deposit carries no means and no weight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("dropped deposit returned data");

   // The store is swept after reset, so no request is taken right away.
   assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("request ready during clearing sweep");

   // No two request transactions are taken back to back.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("back-to-back request transactions taken");

endmodule

bind cubic_spline_momentum_map_2d_unit csm2d_checker u_checker (.*);

[tb/tb_cubic_spline_momentum_map_2d_unit.sv]
// ============================================================================
// tb_cubic_spline_momentum_map_2d_unit
// Self-checking testbench for the 2D cubic spline momentum map.
// A scoreboard class keeps its own copy of the grid sums and the region
// registers. It works out the response of each request transaction that the
// block accepts, and it compares every response field by field in order.
// Directed clears, deposits and reads come first. Random traffic follows,
// aimed at a few cells so that reads find weight, under several region
// settings. The sender and the receiver stall at random, and once the
// receiver holds off long enough to back up the request side.
// ============================================================================
module tb_cubic_spline_momentum_map_2d_unit;
   import csm2d_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]  cmd;
      logic [5:0]  cx, cy;
      logic [15:0] fx, fy;
      logic [31:0] mx, my, mz;
   } particle_req_type;

   typedef struct {
      logic        status;
      logic [31:0] mean_x, mean_y, mean_z;
      logic [47:0] weight;
   } cell_rsp_type;

   typedef logic [3:0][63:0] spline_vec_type;

   class momentum_scoreboard;
      logic [63:0] acc_x[4096], acc_y[4096], acc_z[4096];
      logic [47:0] acc_w[4096];
      logic [5:0]  x_low = 2, x_high = 60, y_low = 2, y_high = 60;
      cell_rsp_type pending[$];
      int          errors = 0;

      // The block sweeps its store to zero after reset.
      function new();
         clear_grid();
      endfunction

      function void clear_grid();
         foreach (acc_x[i]) begin
            acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0; acc_w[i] = 0;
         end
      endfunction

      function void set_reg(logic [1:0] idx, logic [5:0] val);
         case (idx)
            REG_X_LOW:  x_low = val;
            REG_X_HIGH: x_high = val;
            REG_Y_LOW:  y_low = val;
            default:    y_high = val;
         endcase
      endfunction

      function logic [63:0] round16(logic [63:0] v);
         return (v + 64'd32768) >> 16;
      endfunction

      // Numerator (4 - 6s + 3c) is clamped at zero before the division by six.
      function logic [63:0] middle_weight(logic [63:0] sq, logic [63:0] cu);
         longint num;
         num = 4 * 65536 + 3 * longint'(cu) - 6 * longint'(sq);
         if (num < 0) num = 0;
         return (64'(num) + 3) / 6;
      endfunction

      function spline_vec_type spline_weights(logic [15:0] f);
         logic [63:0] t, u, t2, t3, u2, u3;
         spline_vec_type w;
         t = 64'(f);
         u = 64'd65536 - t;
         t2 = round16(t * t);
         t3 = round16(t2 * t);
         u2 = round16(u * u);
         u3 = round16(u2 * u);
         w[0] = (u3 + 3) / 6;
         w[1] = middle_weight(t2, t3);
         w[2] = middle_weight(u2, u3);
         w[3] = (t3 + 3) / 6;
         return w;
      endfunction

      // Momentum share rounds half away from zero.
      function logic [63:0] momentum_share(logic [31:0] mom, logic [63:0] w16);
         longint      m;
         logic [63:0] mag, r;
         m = longint'(signed'(mom));
         mag = (m < 0) ? 64'(-m) : 64'(m);
         r = (mag * w16 + 64'd32768) >> 16;
         return (m < 0) ? -r : r;
      endfunction

      function logic [31:0] weighted_mean(logic [63:0] m, logic [63:0] w);
         logic        neg;
         logic [63:0] mag, q, total;
         if (w == 0) return 0;
         neg = m[63];
         mag = neg ? -m : m;
         q = mag / w;
         if (q > 64'd32768) total = 64'h8000_0000;
         else total = (q << 16) + ((mag % w) << 16) / w;
         if (neg) begin
            if (total > 64'h8000_0000) total = 64'h8000_0000;
            return 32'(-total);
         end
         if (total > 64'h7FFF_FFFF) total = 64'h7FFF_FFFF;
         return total[31:0];
      endfunction

      function void note_request(particle_req_type r);
         cell_rsp_type   e;
         spline_vec_type wx, wy;
         int             gx, gy, idx;
         logic [63:0]    w16;
         e = '{0, 0, 0, 0, 0};
         case (r.cmd)
            CMD_CLEAR: clear_grid();
            CMD_DEPOSIT: begin
               if (r.cx < x_low || r.cx > x_high || r.cy < y_low || r.cy > y_high) begin
                  e.status = 1;
               end else begin
                  wx = spline_weights(r.fx);
                  wy = spline_weights(r.fy);
                  for (int a = 0; a < 4; a++) begin
                     for (int b = 0; b < 4; b++) begin
                        gx = int'(r.cx) - 1 + a;
                        gy = int'(r.cy) - 1 + b;
                        if (gx >= 0 && gx < 64 && gy >= 0 && gy < 64) begin
                           idx = gx * 64 + gy;
                           w16 = round16(wx[a] * wy[b]);
                           acc_x[idx] += momentum_share(r.mx, w16);
                           acc_y[idx] += momentum_share(r.my, w16);
                           acc_z[idx] += momentum_share(r.mz, w16);
                           acc_w[idx] += w16[47:0];
                        end
                     end
                  end
               end
            end
            CMD_READ: begin
               idx = int'(r.cx) * 64 + int'(r.cy);
               e.weight = acc_w[idx];
               e.mean_x = weighted_mean(acc_x[idx], 64'(acc_w[idx]));
               e.mean_y = weighted_mean(acc_y[idx], 64'(acc_w[idx]));
               e.mean_z = weighted_mean(acc_z[idx], 64'(acc_w[idx]));
            end
            default: ;
         endcase
         pending.push_back(e);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
         errors++;
      endtask

      task check_response(cell_rsp_type got);
         cell_rsp_type e;
         if (pending.size() == 0) begin
            report("unexpected response", 64'(got.weight), 0);
         end else begin
            e = pending.pop_front();
            if (got.status !== e.status) report("status", 64'(got.status), 64'(e.status));
            if (got.mean_x !== e.mean_x) report("mean_x", 64'(got.mean_x), 64'(e.mean_x));
            if (got.mean_y !== e.mean_y) report("mean_y", 64'(got.mean_y), 64'(e.mean_y));
            if (got.mean_z !== e.mean_z) report("mean_z", 64'(got.mean_z), 64'(e.mean_z));
            if (got.weight !== e.weight) report("weight_total", 64'(got.weight), 64'(e.weight));
         end
      endtask
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic [1:0]   req_tuser = CMD_CLEAR;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [143:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_we = 0;
   logic [1:0]   csr_index = REG_X_LOW;
   logic [REG_W-1:0] csr_wdata = '0;

   logic         steady = 0;
   logic         hold_start = 0;
   logic         hold_done = 0;
   int           hold_left = 0;

   momentum_scoreboard grid_sb = new();

   cubic_spline_momentum_map_2d_unit dut (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #40ms;
      $display("** cubic_spline_momentum_map_2d_unit: FAILED **");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off to back up the block.
   always @(posedge clock) begin
      if (hold_start && !hold_done) begin
         hold_left <= 700;
         hold_done <= 1;
         rsp_tready <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 37);
      end
   end

   always @(posedge clock) begin
      particle_req_type r;
      cell_rsp_type     s;
      if (csr_we) grid_sb.set_reg(csr_index, csr_wdata);
      if (!reset && req_tvalid && req_tready) begin
         r.cmd = req_tuser;
         {r.mz, r.my, r.mx, r.fy, r.fx, r.cy, r.cx} = req_tdata[139:0];
         grid_sb.note_request(r);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         s.status = rsp_tuser[0];
         {s.weight, s.mean_z, s.mean_y, s.mean_x} = rsp_tdata;
         grid_sb.check_response(s);
      end
   end

   task drive_request(particle_req_type r);
      while (!steady && $urandom_range(99) < 37) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= r.cmd;
      req_tdata <= {4'b0, r.mz, r.my, r.mx, r.fy, r.fx, r.cy, r.cx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task send(logic [1:0] cmd, logic [5:0] cx, logic [5:0] cy, logic [15:0] fx,
             logic [15:0] fy, logic [31:0] mx, logic [31:0] my, logic [31:0] mz);
      particle_req_type r;
      r = '{cmd, cx, cy, fx, fy, mx, my, mz};
      drive_request(r);
   endtask

   task drain();
      req_tvalid <= 0;
      while (grid_sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task set_region(logic [5:0] xl, logic [5:0] xh, logic [5:0] yl, logic [5:0] yh);
      csr_we <= 1;
      csr_index <= REG_X_LOW;  csr_wdata <= xl; @(posedge clock);
      csr_index <= REG_X_HIGH; csr_wdata <= xh; @(posedge clock);
      csr_index <= REG_Y_LOW;  csr_wdata <= yl; @(posedge clock);
      csr_index <= REG_Y_HIGH; csr_wdata <= yh; @(posedge clock);
      csr_we <= 0;
   endtask

   function logic [31:0] pick_momentum();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom_range(2000)) - 32'd1000;
         default: return $urandom;
      endcase
   endfunction

   function logic [15:0] pick_offset();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly deposits and reads clustered around one cell so that reads see
   // accumulated weight; a few clears, idle commands and scattered cells.
   function particle_req_type make_request(logic [5:0] fx0, logic [5:0] fy0);
      particle_req_type r;
      int               k;
      k = $urandom_range(99);
      r.cx = fx0 + 6'($urandom_range(6)) - 6'd3;
      r.cy = fy0 + 6'($urandom_range(6)) - 6'd3;
      if (k >= 90) begin
         r.cx = 6'($urandom);
         r.cy = 6'($urandom);
      end
      r.cmd = (k < 55 || k >= 90) ? CMD_DEPOSIT : (k < 85) ? CMD_READ :
              (k < 87) ? CMD_CLEAR : 2'd3;
      r.fx = pick_offset();
      r.fy = pick_offset();
      r.mx = pick_momentum();
      r.my = pick_momentum();
      r.mz = pick_momentum();
      return r;
   endfunction

   task random_phase(int count);
      logic [5:0] fx0, fy0;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            fx0 = 6'($urandom);
            fy0 = 6'($urandom);
         end
         drive_request(make_request(fx0, fy0));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;

      // Reset region: drops, idle command, spline extremes, zero-weight reads.
      send(2'd3, 6'd5, 6'd5, 16'hFFFF, 16'hFFFF, '1, '1, '1);
      send(CMD_DEPOSIT, 6'd0, 6'd30, 16'h1000, 16'h1000, 32'd65536, 0, 0);
      send(CMD_DEPOSIT, 6'd30, 6'd63, 16'h1000, 16'h1000, 32'd65536, 0, 0);
      send(CMD_DEPOSIT, 6'd2, 6'd2, 16'h0000, 16'h0000,
           32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
      send(CMD_DEPOSIT, 6'd60, 6'd60, 16'hFFFF, 16'hFFFF,
           32'hFFFF_FFFF, 32'd1, 32'h8000_0000);
      send(CMD_DEPOSIT, 6'd30, 6'd30, 16'h8000, 16'h1234, 32'h0003_0000,
           32'hFFFE_8000, 32'h0000_4000);
      send(CMD_DEPOSIT, 6'd30, 6'd30, 16'hFFFF, 16'h0000, 32'h7FFF_FFFF,
           32'h7FFF_FFFF, 32'h8000_0000);
      send(CMD_READ, 6'd1, 6'd1, 0, 0, 0, 0, 0);
      send(CMD_READ, 6'd2, 6'd2, 0, 0, 0, 0, 0);
      send(CMD_READ, 6'd3, 6'd4, 0, 0, 0, 0, 0);
      send(CMD_READ, 6'd61, 6'd61, 0, 0, 0, 0, 0);
      send(CMD_READ, 6'd62, 6'd62, 0, 0, 0, 0, 0);
      send(CMD_READ, 6'd30, 6'd30, 0, 0, 0, 0, 0);
      send(CMD_READ, 6'd31, 6'd29, 0, 0, 0, 0, 0);
      send(CMD_READ, 6'd0, 6'd0, 0, 0, 0, 0, 0);
      send(CMD_READ, 6'd63, 6'd63, 0, 0, 0, 0, 0);
      send(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      send(CMD_READ, 6'd30, 6'd30, 0, 0, 0, 0, 0);
      random_phase(250);
      drain();

      // Whole grid allowed: stencils hang over every edge of the grid.
      set_region(6'd0, 6'd63, 6'd0, 6'd63);
      send(CMD_DEPOSIT, 6'd0, 6'd0, 16'h4000, 16'hC000, 32'h0001_0000, 32'd7, '1);
      send(CMD_DEPOSIT, 6'd63, 6'd63, 16'hC000, 16'h4000, 32'h8000_0000, 0, 1);
      send(CMD_READ, 6'd0, 6'd0, 0, 0, 0, 0, 0);
      send(CMD_READ, 6'd63, 6'd63, 0, 0, 0, 0, 0);
      hold_start <= 1;
      random_phase(250);
      drain();

      // Usual extremes of the region, with no idling on either side.
      set_region(6'd1, 6'd61, 6'd1, 6'd61);
      steady <= 1;
      random_phase(200);
      steady <= 0;
      drain();

      // Low bound above high bound: every deposit is dropped.
      set_region(6'd40, 6'd10, 6'd5, 6'd50);
      random_phase(100);
      drain();

      // Narrow window.
      set_region(6'd30, 6'd33, 6'd28, 6'd35);
      send(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 380; i++) begin
         drive_request(make_request(6'd31, 6'd31));
      end
      drain();

      repeat (150) @(posedge clock);
      if (grid_sb.errors == 0) begin
         $display("** cubic_spline_momentum_map_2d_unit: PASSED **");
      end else begin
         $display("** cubic_spline_momentum_map_2d_unit: FAILED **");
      end
      $finish;
   end
endmodule
